@@ rtl/core/bdrmi_pkg.sv @@
package bdrmi_pkg;

   localparam int QTY_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int MEAN_W  = QTY_W + FRAC_W;
   localparam int LEVEL_W = 4;
   localparam int IMB_W   = 16;
   localparam int FILL_W  = 5;
   localparam int IMB_SHIFT = IMB_W - 1;

   localparam logic [QTY_W-1:0]  COUNT_MAX = '1;
   localparam logic [IMB_W-1:0]  IMB_MAX   = 16'h7fff;
   localparam logic [FILL_W-1:0] FILL_MAX  = '1;

   typedef struct packed {
      logic [QTY_W-1:0] bid_qty;
      logic [QTY_W-1:0] ask_qty;
      logic             bid_present;
      logic             ask_present;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]      level;
      logic [MEAN_W-1:0]       avg_bid;
      logic [MEAN_W-1:0]       avg_ask;
      logic                    snapshot_end;
      logic signed [IMB_W-1:0] imbalance;
      logic [FILL_W-1:0]       bid_filled;
      logic [FILL_W-1:0]       ask_filled;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_IMB_GO,
      ST_IMB_WAIT,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/bdrmi_divider.sv @@
module bdrmi_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one restoring step: bring down the next numerator bit
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      if (fits) begin
         rem_in = DEN_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = trial[DEN_W-1:0];
      end
      quo_in = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

@@ rtl/core/book_depth_running_mean_imbalance.sv @@
// Running per-level mean of order-book depth with snapshot imbalance. Feed
// BOOK_LEVELS items per snapshot, level 0 first; each item returns one result
// carrying that level's updated Q32.16 bid and ask means, and the last item
// of a snapshot also carries the Q1.15 imbalance and the filled-level counts.
// Means live in one synchronous memory (bid and ask side by side), read when
// the item is transferred in and written back before the next one is taken.
// Items are handled one at a time. The final level of a snapshot adds an
// imbalance division after the mean division: the two bit-serial restoring
// dividers retire one quotient bit per cycle, and the bid divider is reused
// for the imbalance. A finished result waits in the output register while the
// next item is accepted; an item whose result finds that register still
// stalled waits until it frees.
module book_depth_running_mean_imbalance #(
   parameter int BOOK_LEVELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bdrmi_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bdrmi_pkg::rsp_type rsp_data
);

   import bdrmi_pkg::*;

   localparam int LVL_W  = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
   localparam int TAL_W  = $clog2(BOOK_LEVELS + 1);
   localparam int SUM_W  = QTY_W + $clog2(BOOK_LEVELS);
   localparam int IMB_NW = SUM_W + IMB_SHIFT;
   localparam int DIV_NW = (IMB_NW > MEAN_W) ? IMB_NW : MEAN_W;
   localparam int DIV_DW = SUM_W + 1;

   state_type state_ff, state_in;

   logic [2*MEAN_W-1:0] mean_mem [BOOK_LEVELS];
   logic [BOOK_LEVELS-1:0] written_ff;
   logic [2*MEAN_W-1:0] rd_data_ff;
   logic                rd_valid_ff;

   logic [LVL_W-1:0] lvl_ff;
   logic [QTY_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0] bid_sum_ff, ask_sum_ff;
   logic [TAL_W-1:0] bid_tally_ff, ask_tally_ff;
   logic [QTY_W-1:0] bq_ff, aq_ff;

   logic [MEAN_W-1:0] avg_bid_ff, avg_ask_ff;
   logic [IMB_W-1:0]  imb_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic accept;
   logic last;
   logic mean_start, imb_start, imb_skip, mean_done, load_out;

   logic [MEAN_W-1:0] old_bid, old_ask;
   logic [MEAN_W:0]   diff_bid, diff_ask;
   logic              neg_bid_ff, neg_ask_ff;
   logic [MEAN_W-1:0] mag_bid, mag_ask;
   logic [MEAN_W-1:0] new_bid, new_ask;

   logic [SUM_W:0]   imb_total;
   logic [SUM_W-1:0] imb_mag;
   logic             imb_neg;
   logic             imb_neg_ff;
   logic [16:0]      imb_q;
   logic [IMB_W-1:0] imb_value;

   logic [DIV_NW-1:0] div_b_num, div_a_num, div_b_quot, div_a_quot;
   logic [DIV_DW-1:0] div_b_den, div_a_den;
   logic              div_b_done, div_a_done;

   assign accept = req_valid && !req_stall;
   assign last   = lvl_ff == LVL_W'(BOOK_LEVELS - 1);

   // snapshot count advances on the first level and holds at its maximum
   always_comb begin
      total_in = total_ff;
      if (lvl_ff == '0 && total_ff != COUNT_MAX) begin
         total_in = total_ff + 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (mean_done) begin
               state_in = last ? ST_IMB_GO : ST_FINISH;
            end
         end
         ST_IMB_GO: begin
            state_in = imb_skip ? ST_FINISH : ST_IMB_WAIT;
         end
         ST_IMB_WAIT: begin
            if (div_b_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      mean_start = state_ff == ST_MEAN_GO;
      mean_done  = state_ff == ST_MEAN_WAIT && div_b_done && div_a_done;
      imb_skip   = imb_total == '0;
      imb_start  = state_ff == ST_IMB_GO && !imb_skip;
      load_out   = state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // mean memory: read on transfer in, write back when the dividers finish
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mean_mem[lvl_ff];
      end
      if (mean_done) begin
         mean_mem[lvl_ff] <= {new_bid, new_ask};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rd_valid_ff <= written_ff[lvl_ff];
         end
         if (mean_done) begin
            written_ff[lvl_ff] <= 1'b1;
         end
      end
   end

   // mean update operands: signed difference split into sign and magnitude
   always_comb begin
      old_bid  = rd_valid_ff ? rd_data_ff[2*MEAN_W-1:MEAN_W] : '0;
      old_ask  = rd_valid_ff ? rd_data_ff[MEAN_W-1:0] : '0;
      diff_bid = {1'b0, bq_ff, {FRAC_W{1'b0}}} - {1'b0, old_bid};
      diff_ask = {1'b0, aq_ff, {FRAC_W{1'b0}}} - {1'b0, old_ask};
      mag_bid  = diff_bid[MEAN_W] ? MEAN_W'(-diff_bid) : diff_bid[MEAN_W-1:0];
      mag_ask  = diff_ask[MEAN_W] ? MEAN_W'(-diff_ask) : diff_ask[MEAN_W-1:0];
   end

   always_comb begin
      if (neg_bid_ff) begin
         new_bid = old_bid - div_b_quot[MEAN_W-1:0];
      end else begin
         new_bid = old_bid + div_b_quot[MEAN_W-1:0];
      end
      if (neg_ask_ff) begin
         new_ask = old_ask - div_a_quot[MEAN_W-1:0];
      end else begin
         new_ask = old_ask + div_a_quot[MEAN_W-1:0];
      end
   end

   // imbalance operands
   always_comb begin
      imb_total = {1'b0, bid_sum_ff} + {1'b0, ask_sum_ff};
      imb_neg   = ask_sum_ff > bid_sum_ff;
      imb_mag   = imb_neg ? ask_sum_ff - bid_sum_ff : bid_sum_ff - ask_sum_ff;
      imb_q     = div_b_quot[16:0];
      if (imb_neg_ff) begin
         imb_value = IMB_W'(17'd0 - imb_q);
      end else if (imb_q > {1'b0, IMB_MAX}) begin
         imb_value = IMB_MAX;
      end else begin
         imb_value = imb_q[IMB_W-1:0];
      end
   end

   always_comb begin
      if (state_ff == ST_IMB_GO) begin
         div_b_num = DIV_NW'({imb_mag, {IMB_SHIFT{1'b0}}});
         div_b_den = imb_total;
      end else begin
         div_b_num = DIV_NW'(mag_bid);
         div_b_den = DIV_DW'(total_ff);
      end
      div_a_num = DIV_NW'(mag_ask);
      div_a_den = DIV_DW'(total_ff);
   end

   bdrmi_divider #(
      .NUM_W (DIV_NW),
      .DEN_W (DIV_DW)
   ) u_div_bid (
      .clock (clock),
      .reset (reset),
      .start (mean_start || imb_start),
      .num   (div_b_num),
      .den   (div_b_den),
      .quot  (div_b_quot),
      .done  (div_b_done)
   );

   bdrmi_divider #(
      .NUM_W (DIV_NW),
      .DEN_W (DIV_DW)
   ) u_div_ask (
      .clock (clock),
      .reset (reset),
      .start (mean_start),
      .num   (div_a_num),
      .den   (div_a_den),
      .quot  (div_a_quot),
      .done  (div_a_done)
   );

   // snapshot bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff       <= '0;
         total_ff     <= '0;
         bid_sum_ff   <= '0;
         ask_sum_ff   <= '0;
         bid_tally_ff <= '0;
         ask_tally_ff <= '0;
      end else begin
         if (accept) begin
            total_ff <= total_in;
            if (req_data.bid_present) begin
               bid_sum_ff   <= bid_sum_ff + SUM_W'(req_data.bid_qty);
               bid_tally_ff <= bid_tally_ff + 1'b1;
            end
            if (req_data.ask_present) begin
               ask_sum_ff   <= ask_sum_ff + SUM_W'(req_data.ask_qty);
               ask_tally_ff <= ask_tally_ff + 1'b1;
            end
         end
         if (load_out) begin
            if (last) begin
               lvl_ff       <= '0;
               bid_sum_ff   <= '0;
               ask_sum_ff   <= '0;
               bid_tally_ff <= '0;
               ask_tally_ff <= '0;
            end else begin
               lvl_ff <= lvl_ff + 1'b1;
            end
         end
      end
   end

   // item payload and intermediate results
   always_ff @(posedge clock) begin
      if (accept) begin
         bq_ff <= req_data.bid_present ? req_data.bid_qty : '0;
         aq_ff <= req_data.ask_present ? req_data.ask_qty : '0;
      end
      if (mean_start) begin
         neg_bid_ff <= diff_bid[MEAN_W];
         neg_ask_ff <= diff_ask[MEAN_W];
      end
      if (mean_done) begin
         avg_bid_ff <= new_bid;
         avg_ask_ff <= new_ask;
         imb_ff     <= '0;
      end
      if (state_ff == ST_IMB_GO) begin
         imb_neg_ff <= imb_neg;
      end
      if (state_ff == ST_IMB_WAIT && div_b_done) begin
         imb_ff <= imb_value;
      end
   end

   // output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.level        <= LEVEL_W'(lvl_ff);
         rsp_data_ff.avg_bid      <= avg_bid_ff;
         rsp_data_ff.avg_ask      <= avg_ask_ff;
         rsp_data_ff.snapshot_end <= last;
         if (last) begin
            rsp_data_ff.imbalance  <= imb_ff;
            rsp_data_ff.bid_filled <= (32'(bid_tally_ff) > 32'(FILL_MAX)) ?
                                      FILL_MAX : FILL_W'(bid_tally_ff);
            rsp_data_ff.ask_filled <= (32'(ask_tally_ff) > 32'(FILL_MAX)) ?
                                      FILL_MAX : FILL_W'(ask_tally_ff);
         end else begin
            rsp_data_ff.imbalance  <= '0;
            rsp_data_ff.bid_filled <= '0;
            rsp_data_ff.ask_filled <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
